>>> hw/rtl/cwpd_pkg.sv
// ----------------------------------------------------------------------------
// cwpd_pkg: shared types and constants for the can wake pattern detector
// item and result layouts, detector phase codes, bus and mode codes
// ----------------------------------------------------------------------------
package cwpd_pkg;

  localparam int unsigned TimeBits   = 48;
  localparam int unsigned FilterBits = 20;
  localparam int unsigned TimeoutBits = 24;
  localparam int unsigned CfgDataBits = 24;
  localparam int unsigned InDataBits  = 56;
  localparam int unsigned OutDataBits = 8;

  localparam logic [FilterBits-1:0]  FilterReset  = FilterBits'(500);
  localparam logic [TimeoutBits-1:0] TimeoutReset = TimeoutBits'(2000000);

  // register indexes on the config port
  localparam logic CfgFilter  = 1'b0;
  localparam logic CfgTimeout = 1'b1;

  // bus level codes (anything else is undetermined)
  localparam logic [1:0] BusRec = 2'd0;
  localparam logic [1:0] BusDom = 2'd1;

  // operating mode codes
  localparam logic [1:0] ModeStandby = 2'd1;
  localparam logic [1:0] ModeSleep   = 2'd2;

  // reported phase codes
  localparam logic [2:0] CodeIdle = 3'd0;
  localparam logic [2:0] CodeDom1 = 3'd1;
  localparam logic [2:0] CodeRec  = 3'd2;
  localparam logic [2:0] CodeDom2 = 3'd3;
  localparam logic [2:0] CodeDone = 3'd4;

  typedef enum logic [4:0] {
    PH_IDLE = 5'b00001,
    PH_DOM1 = 5'b00010,
    PH_REC  = 5'b00100,
    PH_DOM2 = 5'b01000,
    PH_DONE = 5'b10000
  } phase_e;

  typedef struct packed {
    logic                command;
    logic [1:0]          bus_level;
    logic                wake_pin;
    logic [1:0]          op_mode;
    logic [TimeBits-1:0] timestamp_ns;
  } item_t;

  typedef struct packed {
    logic       wake_request;
    logic       wake_status;
    logic       wake_was_local;
    logic [2:0] pattern_phase;
  } result_t;

  typedef struct packed {
    logic [FilterBits-1:0]  filter_len;
    logic [TimeoutBits-1:0] window_len;
  } cfg_t;

  function automatic logic [2:0] phase_code(phase_e ph);
    logic [2:0] code;
    case (ph)
      PH_IDLE: code = CodeIdle;
      PH_DOM1: code = CodeDom1;
      PH_REC:  code = CodeRec;
      PH_DOM2: code = CodeDom2;
      PH_DONE: code = CodeDone;
      default: code = CodeIdle;
    endcase
    return code;
  endfunction

endpackage

>>> hw/rtl/cwpd_cfg.sv
// ----------------------------------------------------------------------------
// cwpd_cfg: configuration registers
// filter time and timeout, written through a plain write port
// ----------------------------------------------------------------------------
module cwpd_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic                                cfg_index_i,
  input  logic [cwpd_pkg::CfgDataBits-1:0]    cfg_data_i,
  output cwpd_pkg::cfg_t                      cfg_o
);

  logic [cwpd_pkg::FilterBits-1:0]  filter_q;
  logic [cwpd_pkg::TimeoutBits-1:0] timeout_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filter_q  <= cwpd_pkg::FilterReset;
      timeout_q <= cwpd_pkg::TimeoutReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        cwpd_pkg::CfgFilter:  filter_q  <= cfg_data_i[cwpd_pkg::FilterBits-1:0];
        cwpd_pkg::CfgTimeout: timeout_q <= cfg_data_i[cwpd_pkg::TimeoutBits-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o.filter_len = filter_q;
  assign cfg_o.window_len = timeout_q;

endmodule

>>> hw/rtl/cwpd_core.sv
// ----------------------------------------------------------------------------
// cwpd_core: wake detector state and single-pass update
// computes the next detector state and flags for one item
// ----------------------------------------------------------------------------
module cwpd_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_i,
  input  cwpd_pkg::item_t item_i,
  input  cwpd_pkg::cfg_t  cfg_i,
  output cwpd_pkg::result_t result_o
);

  localparam int unsigned TB = cwpd_pkg::TimeBits;

  cwpd_pkg::phase_e phase_q, phase_d;
  logic [TB-1:0]    phase_start_q, phase_start_d;
  logic [TB-1:0]    pat_start_q, pat_start_d;
  logic             req_q, req_d;
  logic             stat_q, stat_d;
  logic             local_q, local_d;
  logic             prev_pin_q, prev_pin_d;

  logic [TB-1:0] since_phase;
  logic [TB-1:0] since_pattern;
  logic          filter_met;
  logic          timed_out;
  logic          in_pattern;
  logic          is_dom;
  logic          is_rec;
  logic          active_mode;

  assign since_phase   = item_i.timestamp_ns - phase_start_q;
  assign since_pattern = item_i.timestamp_ns - pat_start_q;
  assign filter_met    = since_phase >= TB'(cfg_i.filter_len);
  assign in_pattern    = (phase_q == cwpd_pkg::PH_DOM1) || (phase_q == cwpd_pkg::PH_REC) ||
                         (phase_q == cwpd_pkg::PH_DOM2);
  assign timed_out     = in_pattern && (since_pattern >= TB'(cfg_i.window_len));
  assign is_dom        = item_i.bus_level == cwpd_pkg::BusDom;
  assign is_rec        = item_i.bus_level == cwpd_pkg::BusRec;
  assign active_mode   = (item_i.op_mode == cwpd_pkg::ModeStandby) ||
                         (item_i.op_mode == cwpd_pkg::ModeSleep);

  always_comb begin
    phase_d       = phase_q;
    phase_start_d = phase_start_q;
    pat_start_d   = pat_start_q;
    req_d         = req_q;
    stat_d        = stat_q;
    local_d       = local_q;
    prev_pin_d    = prev_pin_q;
    if (item_i.command) begin
      req_d   = 1'b0;
      phase_d = cwpd_pkg::PH_IDLE;
    end else begin
      if (active_mode) begin
        if (timed_out) begin
          phase_d = cwpd_pkg::PH_IDLE;
        end else begin
          case (phase_q)
            cwpd_pkg::PH_IDLE: begin
              if (is_dom) begin
                phase_d       = cwpd_pkg::PH_DOM1;
                phase_start_d = item_i.timestamp_ns;
                pat_start_d   = item_i.timestamp_ns;
              end
            end
            cwpd_pkg::PH_DOM1: begin
              if (!is_dom) begin
                phase_d = cwpd_pkg::PH_IDLE;
              end else if (filter_met) begin
                phase_d       = cwpd_pkg::PH_REC;
                phase_start_d = item_i.timestamp_ns;
              end
            end
            cwpd_pkg::PH_REC: begin
              // undetermined bus leaves the recessive phase alone
              if (is_rec || is_dom) begin
                if (filter_met) begin
                  phase_d       = cwpd_pkg::PH_DOM2;
                  phase_start_d = item_i.timestamp_ns;
                end else if (is_dom) begin
                  phase_d = cwpd_pkg::PH_IDLE;
                end
              end
            end
            cwpd_pkg::PH_DOM2: begin
              if (!is_dom) begin
                phase_d = cwpd_pkg::PH_IDLE;
              end else if (filter_met) begin
                phase_d = cwpd_pkg::PH_DONE;
                req_d   = 1'b1;
                stat_d  = 1'b1;
                local_d = 1'b0;
              end
            end
            default: ;
          endcase
        end
        // local wake: any pin edge while asleep
        if ((item_i.op_mode == cwpd_pkg::ModeSleep) && (item_i.wake_pin != prev_pin_q)) begin
          req_d   = 1'b1;
          stat_d  = 1'b1;
          local_d = 1'b1;
          phase_d = cwpd_pkg::PH_IDLE;
        end
      end else begin
        phase_d = cwpd_pkg::PH_IDLE;
      end
      prev_pin_d = item_i.wake_pin;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= cwpd_pkg::PH_IDLE;
      req_q      <= 1'b0;
      stat_q     <= 1'b0;
      local_q    <= 1'b0;
      prev_pin_q <= 1'b0;
    end else if (step_i) begin
      phase_q    <= phase_d;
      req_q      <= req_d;
      stat_q     <= stat_d;
      local_q    <= local_d;
      prev_pin_q <= prev_pin_d;
    end
  end

  // start times only matter outside idle
  always_ff @(posedge clk_i) begin
    if (step_i) begin
      phase_start_q <= phase_start_d;
      pat_start_q   <= pat_start_d;
    end
  end

  assign result_o.wake_request   = req_d;
  assign result_o.wake_status    = stat_d;
  assign result_o.wake_was_local = local_d;
  assign result_o.pattern_phase  = cwpd_pkg::phase_code(phase_d);

endmodule

>>> hw/rtl/can_wake_pattern_detector.sv
// ----------------------------------------------------------------------------
// can_wake_pattern_detector: can transceiver wake-up detector
// remote wake pattern and local wake pin detection on a sample stream
// ----------------------------------------------------------------------------
// usage
//   s_axis carries one beat per bus sample or clear command; tuser is the
//   command bit, tdata packs bus level, wake pin, mode and a 48-bit timestamp.
//   m_axis returns exactly one beat per input beat with the wake flags and
//   the detector phase as they stand after that item.
//   cfg_we_i / cfg_index_i / cfg_data_i write the filter time (index 0) and
//   the timeout (index 1); write them only while no beat is in flight.
// timing
//   an accepted beat lands in the input register, the detector update runs
//   in one pass from there into the output register, which drives m_axis.
//   one beat per cycle sustained while m_axis_tready stays high; the state
//   registers close their loop in the same cycle, so there is no bubble
//   between dependent samples.
// reset
//   rst_ni clears both pipeline valids, the flags, the pin history and puts
//   the detector idle; config returns to 500 ns filter and 2 ms timeout.
// stall
//   when m_axis_tready is low the output register holds its beat, the input
//   register still fills once, then s_axis_tready drops until space frees.
// ----------------------------------------------------------------------------
module can_wake_pattern_detector (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [1:0] bus_level, [2] wake_pin, [4:3] op_mode, [52:5] timestamp_ns, rest zero
  input  logic [cwpd_pkg::InDataBits-1:0]     s_axis_tdata,
  // [0] command
  input  logic                                s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [0] wake_request, [1] wake_status, [2] wake_was_local, [5:3] pattern_phase
  output logic [cwpd_pkg::OutDataBits-1:0]    m_axis_tdata,
  input  logic                                cfg_we_i,
  input  logic                                cfg_index_i,
  input  logic [cwpd_pkg::CfgDataBits-1:0]    cfg_data_i
);

  cwpd_pkg::cfg_t    cfg;
  cwpd_pkg::item_t   in_item;
  cwpd_pkg::item_t   item_q;
  cwpd_pkg::result_t result;
  cwpd_pkg::result_t out_q;
  logic              item_valid_q;
  logic              out_valid_q;
  logic              advance;

  // unpack the incoming beat
  assign in_item.command      = s_axis_tuser;
  assign in_item.bus_level    = s_axis_tdata[1:0];
  assign in_item.wake_pin     = s_axis_tdata[2];
  assign in_item.op_mode      = s_axis_tdata[4:3];
  assign in_item.timestamp_ns = s_axis_tdata[52:5];

  // input register moves on when the output register is free or draining
  assign advance       = item_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !item_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        item_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      item_q <= in_item;
    end
    if (advance) begin
      out_q <= result;
    end
  end

  cwpd_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // state advances exactly once per beat leaving the input register
  cwpd_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .item_i   (item_q),
    .cfg_i    (cfg),
    .result_o (result)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_q.pattern_phase, out_q.wake_was_local,
                          out_q.wake_status, out_q.wake_request};

endmodule

>>> tb/tb_can_wake_pattern_detector.sv
// ----------------------------------------------------------------------------
// tb_can_wake_pattern_detector: self-checking bench for the can wake detector
// drives bus/pin/mode samples and clear commands on the input stream, keeps
// its own copy of the wake detector state and checks every output beat
// against it, with random idle on both sides and several filter/timeout
// settings, the register extremes among them
// ----------------------------------------------------------------------------
module tb_can_wake_pattern_detector;

  // codes the package does not name
  localparam logic       CmdSample = 1'b0;
  localparam logic       CmdClear  = 1'b1;
  localparam logic [1:0] BusUndet  = 2'd2;
  localparam logic [1:0] BusSpare  = 2'd3;
  localparam logic [1:0] ModeNormal = 2'd0;
  localparam logic [1:0] ModeOther  = 2'd3;

  logic                             clk_i;
  logic                             rst_ni;
  logic                             s_axis_tvalid;
  logic                             s_axis_tready;
  logic [cwpd_pkg::InDataBits-1:0]  s_axis_tdata;
  logic                             s_axis_tuser;
  logic                             m_axis_tvalid;
  logic                             m_axis_tready;
  logic [cwpd_pkg::OutDataBits-1:0] m_axis_tdata;
  logic                             cfg_we_i;
  logic                             cfg_index_i;
  logic [cwpd_pkg::CfgDataBits-1:0] cfg_data_i;

  can_wake_pattern_detector u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // own copy of the detector: config, phase, timing and flags
  logic [cwpd_pkg::FilterBits-1:0]  cfg_filter;
  logic [cwpd_pkg::TimeoutBits-1:0] cfg_timeout;
  logic [2:0]                       det_phase;
  logic [cwpd_pkg::TimeBits-1:0]    det_phase_t0;
  logic [cwpd_pkg::TimeBits-1:0]    det_pattern_t0;
  logic                             flag_req;
  logic                             flag_status;
  logic                             flag_local;
  logic                             last_pin;

  // results still owed by the block, oldest first
  cwpd_pkg::result_t wake_exp_q[$];

  int unsigned beat_cnt;      // input beats handed to the block
  int unsigned result_cnt;    // output beats checked
  int unsigned mismatch_cnt;
  bit          stall_en;      // random idling on both sides when set

  // stimulus state: running time base and current wake pin level
  logic [cwpd_pkg::TimeBits-1:0] now_ns;
  logic                          pin_lvl;

  // --------------------------------------------------------------------------
  // clock and run limit
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run limit, well beyond the slowest legal run
  initial begin
    #5000000;
    $display("Mismatches found");
    $finish;
  end

  // --------------------------------------------------------------------------
  // detector prediction
  // --------------------------------------------------------------------------
  function automatic void detector_idle();
    det_phase      = cwpd_pkg::CodeIdle;
    det_phase_t0   = '0;
    det_pattern_t0 = '0;
  endfunction

  function automatic void detector_reset();
    cfg_filter  = cwpd_pkg::FilterReset;
    cfg_timeout = cwpd_pkg::TimeoutReset;
    detector_idle();
    flag_req    = 1'b0;
    flag_status = 1'b0;
    flag_local  = 1'b0;
    last_pin    = 1'b0;
  endfunction

  // one bus evaluation step of the pattern search (standby or sleep only)
  function automatic void detector_bus_step(logic [1:0] bus,
                                            logic [cwpd_pkg::TimeBits-1:0] now);
    logic [cwpd_pkg::TimeBits-1:0] pat_age;
    logic [cwpd_pkg::TimeBits-1:0] ph_age;
    logic                          in_pattern;
    pat_age    = now - det_pattern_t0;
    ph_age     = now - det_phase_t0;
    in_pattern = (det_phase == cwpd_pkg::CodeDom1) || (det_phase == cwpd_pkg::CodeRec) ||
                 (det_phase == cwpd_pkg::CodeDom2);
    // timeout wins over any bus evaluation on this step
    if (in_pattern && (pat_age >= cwpd_pkg::TimeBits'(cfg_timeout))) begin
      detector_idle();
      return;
    end
    case (det_phase)
      cwpd_pkg::CodeIdle: begin
        if (bus == cwpd_pkg::BusDom) begin
          det_phase      = cwpd_pkg::CodeDom1;
          det_phase_t0   = now;
          det_pattern_t0 = now;
        end
      end
      cwpd_pkg::CodeDom1: begin
        if (bus == cwpd_pkg::BusDom) begin
          if (ph_age >= cwpd_pkg::TimeBits'(cfg_filter)) begin
            det_phase    = cwpd_pkg::CodeRec;
            det_phase_t0 = now;
          end
        end else begin
          detector_idle();
        end
      end
      cwpd_pkg::CodeRec: begin
        // undetermined bus leaves the recessive phase alone
        if ((bus == cwpd_pkg::BusRec) || (bus == cwpd_pkg::BusDom)) begin
          if (ph_age >= cwpd_pkg::TimeBits'(cfg_filter)) begin
            det_phase    = cwpd_pkg::CodeDom2;
            det_phase_t0 = now;
          end else if (bus == cwpd_pkg::BusDom) begin
            detector_idle();
          end
        end
      end
      cwpd_pkg::CodeDom2: begin
        if (bus == cwpd_pkg::BusDom) begin
          if (ph_age >= cwpd_pkg::TimeBits'(cfg_filter)) begin
            flag_req       = 1'b1;
            flag_status    = 1'b1;
            flag_local     = 1'b0;
            det_phase      = cwpd_pkg::CodeDone;
            det_phase_t0   = '0;
            det_pattern_t0 = '0;
          end
        end else begin
          detector_idle();
        end
      end
      default: ;  // complete phase is held
    endcase
  endfunction

  function automatic cwpd_pkg::result_t wake_predict(logic cmd, logic [1:0] bus, logic pin,
                                                     logic [1:0] mode,
                                                     logic [cwpd_pkg::TimeBits-1:0] now);
    cwpd_pkg::result_t res;
    if (cmd == CmdClear) begin
      flag_req = 1'b0;
      detector_idle();
    end else begin
      if ((mode == cwpd_pkg::ModeStandby) || (mode == cwpd_pkg::ModeSleep)) begin
        detector_bus_step(bus, now);
        // pin edge is a wake source only in sleep
        if ((mode == cwpd_pkg::ModeSleep) && (pin != last_pin)) begin
          flag_req    = 1'b1;
          flag_status = 1'b1;
          flag_local  = 1'b1;
          detector_idle();
        end
      end else begin
        detector_idle();
      end
      last_pin = pin;
    end
    res.wake_request   = flag_req;
    res.wake_status    = flag_status;
    res.wake_was_local = flag_local;
    res.pattern_phase  = det_phase;
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // sender side
  // --------------------------------------------------------------------------
  // one input beat; the expectation is queued as soon as the beat is offered,
  // it is sure to be taken and the result only comes back through the output register
  task automatic send_beat(logic cmd, logic [1:0] bus, logic pin, logic [1:0] mode,
                           logic [cwpd_pkg::TimeBits-1:0] ts);
    int gap;
    gap = stall_en ? $urandom_range(0, 5) : 0;
    repeat (gap) begin
      @(negedge clk_i);
      s_axis_tvalid = 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = cmd;
    s_axis_tdata  = {3'b000, ts, mode, pin, bus};
    wake_exp_q.push_back(wake_predict(cmd, bus, pin, mode, ts));
    beat_cnt++;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // clear command with junk in every ignored field
  task automatic send_clear();
    send_beat(CmdClear, 2'($urandom), 1'($urandom), 2'($urandom),
              {16'($urandom), 32'($urandom)});
  endtask

  // stop offering beats and wait until every owed result has come back
  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (wake_exp_q.size() != 0) @(posedge clk_i);
    // two-stage pipe, give it a little extra
    repeat (4) @(posedge clk_i);
  endtask

  // register write, only with the block idle
  task automatic write_cfg(logic idx, logic [cwpd_pkg::CfgDataBits-1:0] data);
    drain_results();
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    if (idx == cwpd_pkg::CfgFilter) cfg_filter = data[cwpd_pkg::FilterBits-1:0];
    else cfg_timeout = data[cwpd_pkg::TimeoutBits-1:0];
    @(negedge clk_i);
    cfg_we_i   = 1'b0;
    cfg_data_i = '0;
  endtask

  // --------------------------------------------------------------------------
  // receiver side: random stall before each result beat
  // --------------------------------------------------------------------------
  initial begin
    int hold;
    m_axis_tready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      hold = stall_en ? $urandom_range(0, 5) : 0;
      repeat (hold) begin
        @(negedge clk_i);
        m_axis_tready = 1'b0;
      end
      @(negedge clk_i);
      m_axis_tready = 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  // --------------------------------------------------------------------------
  // result checker: every accepted output beat against the oldest expectation
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    cwpd_pkg::result_t exp_res;
    cwpd_pkg::result_t act_res;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      act_res.wake_request   = m_axis_tdata[0];
      act_res.wake_status    = m_axis_tdata[1];
      act_res.wake_was_local = m_axis_tdata[2];
      act_res.pattern_phase  = m_axis_tdata[5:3];
      if (wake_exp_q.size() == 0) begin
        if (mismatch_cnt < 10)
          $display("ERROR: unexpected result beat, tdata %h", m_axis_tdata);
        mismatch_cnt++;
      end else begin
        exp_res = wake_exp_q.pop_front();
        if ((act_res.wake_request   !== exp_res.wake_request) ||
            (act_res.wake_status    !== exp_res.wake_status) ||
            (act_res.wake_was_local !== exp_res.wake_was_local) ||
            (act_res.pattern_phase  !== exp_res.pattern_phase)) begin
          if (mismatch_cnt < 10)
            $display("ERROR: result %0d req %b/%b status %b/%b local %b/%b phase %0d/%0d",
                     result_cnt, exp_res.wake_request, act_res.wake_request,
                     exp_res.wake_status, act_res.wake_status,
                     exp_res.wake_was_local, act_res.wake_was_local,
                     exp_res.pattern_phase, act_res.pattern_phase);
          mismatch_cnt++;
        end
      end
      result_cnt++;
    end
  end

  // --------------------------------------------------------------------------
  // directed tests
  // --------------------------------------------------------------------------
  // full remote pattern at reset settings, running across the 48-bit wrap
  task automatic test_remote_wake();
    logic [cwpd_pkg::TimeBits-1:0] t0;
    t0 = 48'hFFFF_FFFF_FE00;
    send_beat(CmdSample, cwpd_pkg::BusDom, 1'b0, cwpd_pkg::ModeStandby, t0);  // first dominant
    send_beat(CmdSample, cwpd_pkg::BusDom, 1'b0, cwpd_pkg::ModeStandby, t0 + 250);  // too short
    send_beat(CmdSample, cwpd_pkg::BusDom, 1'b0, cwpd_pkg::ModeStandby, t0 + 500);  // recessive
    send_beat(CmdSample, cwpd_pkg::BusRec, 1'b0, cwpd_pkg::ModeStandby, t0 + 1000); // second dom
    send_beat(CmdSample, cwpd_pkg::BusDom, 1'b0, cwpd_pkg::ModeStandby, t0 + 1500); // complete
    send_beat(CmdSample, BusUndet, 1'b0, cwpd_pkg::ModeStandby, t0 + 1600);  // complete held
    send_clear();                                                            // status stays set
  endtask

  // undetermined bus: kills a dominant phase, ignored in the recessive one
  task automatic test_bus_undetermined();
    logic [cwpd_pkg::TimeBits-1:0] t1;
    t1 = 48'd1000;
    send_beat(CmdSample, cwpd_pkg::BusDom, 1'b0, cwpd_pkg::ModeStandby, t1);
    send_beat(CmdSample, BusUndet,         1'b0, cwpd_pkg::ModeStandby, t1 + 100);
    send_beat(CmdSample, cwpd_pkg::BusDom, 1'b0, cwpd_pkg::ModeStandby, t1 + 200);
    send_beat(CmdSample, cwpd_pkg::BusDom, 1'b0, cwpd_pkg::ModeStandby, t1 + 700);
    send_beat(CmdSample, BusSpare,         1'b0, cwpd_pkg::ModeStandby, t1 + 800);
    // early dominant in the recessive phase drops back to idle
    send_beat(CmdSample, cwpd_pkg::BusDom, 1'b0, cwpd_pkg::ModeStandby, t1 + 900);
  endtask

  // pin edges: wake in sleep, only tracked in standby, detector idle elsewhere
  task automatic test_local_wake();
    send_beat(CmdSample, cwpd_pkg::BusRec, 1'b1, cwpd_pkg::ModeSleep, 48'hFFFF_FFFF_FFFF);
    send_clear();
    send_beat(CmdSample, cwpd_pkg::BusRec, 1'b0, cwpd_pkg::ModeStandby, 48'd5);
    send_beat(CmdSample, cwpd_pkg::BusDom, 1'b1, ModeNormal,            48'd0);
    send_beat(CmdSample, cwpd_pkg::BusDom, 1'b1, ModeOther,             48'd10);
  endtask

  // timeout in the middle of a pattern, plus zero and max register values
  task automatic test_timeout_and_limits();
    logic [cwpd_pkg::TimeBits-1:0] t2;
    t2 = 48'h0000_8000_0000;
    write_cfg(cwpd_pkg::CfgTimeout, 24'd800);
    send_beat(CmdSample, cwpd_pkg::BusDom, 1'b1, cwpd_pkg::ModeSleep, t2);
    send_beat(CmdSample, cwpd_pkg::BusDom, 1'b1, cwpd_pkg::ModeSleep, t2 + 500);
    // timeout and pin edge on the same step
    send_beat(CmdSample, cwpd_pkg::BusRec, 1'b0, cwpd_pkg::ModeSleep, t2 + 900);
    send_clear();
    write_cfg(cwpd_pkg::CfgFilter, 24'd0);
    write_cfg(cwpd_pkg::CfgTimeout, 24'd0);
    send_beat(CmdSample, cwpd_pkg::BusDom, 1'b0, cwpd_pkg::ModeStandby, t2);
    send_beat(CmdSample, cwpd_pkg::BusDom, 1'b0, cwpd_pkg::ModeStandby, t2);
    // zero filter, widest window: whole pattern on one timestamp
    write_cfg(cwpd_pkg::CfgTimeout, 24'hFF_FFFF);
    send_beat(CmdSample, cwpd_pkg::BusDom, 1'b0, cwpd_pkg::ModeStandby, t2);
    send_beat(CmdSample, cwpd_pkg::BusDom, 1'b0, cwpd_pkg::ModeStandby, t2);
    send_beat(CmdSample, cwpd_pkg::BusRec, 1'b0, cwpd_pkg::ModeStandby, t2);
    send_beat(CmdSample, cwpd_pkg::BusDom, 1'b0, cwpd_pkg::ModeStandby, t2);
  endtask

  // --------------------------------------------------------------------------
  // random traffic
  // --------------------------------------------------------------------------
  // one dominant / recessive / dominant attempt with random phase lengths,
  // occasionally broken by a stray bus level, a mode change or a pin edge
  task automatic drive_wake_attempt();
    logic [1:0] mode;
    logic [1:0] bus;
    int         cnt;
    int         span;
    int         ph;
    int         k;
    mode = $urandom_range(0, 1) ? cwpd_pkg::ModeSleep : cwpd_pkg::ModeStandby;
    span = int'(cfg_filter) / 2 + 1;
    for (ph = 0; ph < 4; ph++) begin
      cnt = (ph == 3) ? $urandom_range(0, 2) : $urandom_range(1, 6);
      for (k = 0; k < cnt; k++) begin
        bus = (ph == 1) ? cwpd_pkg::BusRec : cwpd_pkg::BusDom;
        if (ph == 3) bus = 2'($urandom);                 // tail after the pattern
        if ($urandom_range(0, 15) == 0) bus = 2'($urandom);
        if ($urandom_range(0, 39) == 0) pin_lvl = ~pin_lvl;
        if ($urandom_range(0, 31) == 0) mode = 2'($urandom);
        now_ns = now_ns + cwpd_pkg::TimeBits'($urandom_range(0, span));
        send_beat(CmdSample, bus, pin_lvl, mode, now_ns);
      end
    end
    if ($urandom_range(0, 1) == 0) send_clear();
  endtask

  // a few fully random beats: any mode, any level, time jumps
  task automatic drive_noise();
    int n;
    n = $urandom_range(1, 4);
    repeat (n) begin
      if ($urandom_range(0, 7) == 0) begin
        send_clear();
      end else begin
        if ($urandom_range(0, 3) == 0) pin_lvl = ~pin_lvl;
        if ($urandom_range(0, 15) == 0) now_ns = {16'($urandom), 32'($urandom)};
        else now_ns = now_ns + cwpd_pkg::TimeBits'($urandom_range(0, 4000));
        send_beat(CmdSample, 2'($urandom), pin_lvl, 2'($urandom), now_ns);
      end
    end
  endtask

  task automatic run_random_setting(logic [cwpd_pkg::CfgDataBits-1:0] filter_data,
                                    logic [cwpd_pkg::CfgDataBits-1:0] timeout_data,
                                    bit idle, int unsigned n_beats, bit pause_mid);
    int unsigned start;
    bit          paused;
    write_cfg(cwpd_pkg::CfgFilter, filter_data);
    write_cfg(cwpd_pkg::CfgTimeout, timeout_data);
    stall_en = idle;
    start    = beat_cnt;
    paused   = 1'b0;
    while (beat_cnt - start < n_beats) begin
      if ($urandom_range(0, 4) == 0) drive_noise();
      else drive_wake_attempt();
      // let the pipe run dry once while traffic is going
      if (pause_mid && !paused && (beat_cnt - start > n_beats / 2)) begin
        drain_results();
        paused = 1'b1;
      end
    end
  endtask

  task automatic test_random_traffic();
    logic [cwpd_pkg::FilterBits-1:0] f;
    now_ns  = {16'($urandom), 32'($urandom)};
    pin_lvl = last_pin;
    // reset values, upper data bits of the filter write set at random
    run_random_setting({4'($urandom), 20'd500}, 24'd2000000, 1'b1, 300, 1'b0);
    // no filter, tight window
    run_random_setting(24'd0, 24'($urandom_range(0, 3000)), 1'b1, 300, 1'b0);
    // window close to the pattern length, no idling, one drain in the middle
    f = cwpd_pkg::FilterBits'($urandom_range(1, 2000));
    run_random_setting(24'(f), 24'(3 * f + $urandom_range(0, 2 * f)), 1'b0, 300, 1'b1);
    // register maxima
    run_random_setting({4'($urandom), 20'hF_FFFF}, 24'hFF_FFFF, 1'b1, 300, 1'b0);
    // anything goes
    run_random_setting(24'($urandom), 24'($urandom), 1'b1, 300, 1'b0);
    // zero window with a short filter
    run_random_setting(24'($urandom_range(0, 300)), 24'd0, 1'b1, 250, 1'b0);
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = cwpd_pkg::CfgFilter;
    cfg_data_i    = '0;
    beat_cnt      = 0;
    result_cnt    = 0;
    mismatch_cnt  = 0;
    stall_en      = 1'b1;
    now_ns        = '0;
    pin_lvl       = 1'b0;
    detector_reset();
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_remote_wake();
    test_bus_undetermined();
    test_local_wake();
    test_timeout_and_limits();
    test_random_traffic();

    drain_results();
    repeat (10) @(posedge clk_i);
    // expectations nobody answered
    if (wake_exp_q.size() != 0) begin
      if (mismatch_cnt < 10)
        $display("ERROR: %0d results never arrived", wake_exp_q.size());
      mismatch_cnt += wake_exp_q.size();
    end
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
